>>> rtl/core/lsd_radix_sort_24bit_keys_top_defines.svh
// Assertion macros shared by the radix sorter modules.
`ifndef LSD_RADIX_SORT_24BIT_KEYS_TOP_DEFINES_SVH
`define LSD_RADIX_SORT_24BIT_KEYS_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define LRS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define LRS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LRS_ASSERT_IMP(lbl, ante, cons, msg)
`define LRS_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

>>> rtl/core/lrs_pkg.sv
// Shared types, constants and command codes of the radix sorter.
package lrs_pkg;
    localparam int KEY_W = 24;
    localparam int TAG_W = 10;
    localparam int REC_W = KEY_W + TAG_W;
    localparam int DEF_MAX_ITEMS = 1024;
    localparam int DEF_DIGIT_BITS = 8;
    localparam int DEF_NUM_PASSES = 3;
    localparam int OP_W = 4;

    localparam logic OPC_PUSH = 1'b0;
    localparam logic OPC_POP  = 1'b1;

    localparam logic [OP_W-1:0] CMD_NONE      = 4'd0;
    localparam logic [OP_W-1:0] CMD_PUSH      = 4'd1;
    localparam logic [OP_W-1:0] CMD_POP_START = 4'd2;
    localparam logic [OP_W-1:0] CMD_POP_EMPTY = 4'd3;
    localparam logic [OP_W-1:0] CMD_POP_DONE  = 4'd4;
    localparam logic [OP_W-1:0] CMD_CLR       = 4'd5;
    localparam logic [OP_W-1:0] CMD_CNT_RD    = 4'd6;
    localparam logic [OP_W-1:0] CMD_CNT_HR    = 4'd7;
    localparam logic [OP_W-1:0] CMD_CNT_WR    = 4'd8;
    localparam logic [OP_W-1:0] CMD_PRE_RD    = 4'd9;
    localparam logic [OP_W-1:0] CMD_PRE_WR    = 4'd10;
    localparam logic [OP_W-1:0] CMD_SC_RD     = 4'd11;
    localparam logic [OP_W-1:0] CMD_SC_HR     = 4'd12;
    localparam logic [OP_W-1:0] CMD_SC_WR     = 4'd13;

    typedef struct packed {
        logic              opcode;
        logic [KEY_W-1:0]  sort_key;
        logic [TAG_W-1:0]  record_tag;
        logic              final_record;
    } t_cmd_item;

    typedef struct packed {
        logic [TAG_W-1:0]  out_tag;
        logic [KEY_W-1:0]  out_key;
        logic              out_last;
        logic              out_valid;
    } t_res_item;

    typedef struct packed {
        logic [OP_W-1:0] op;
    } t_dp_cmd;

    typedef struct packed {
        logic idx_last;
        logic bin_last;
        logic pass_last;
        logic pop_avail;
        logic res_free;
    } t_dp_status;
endpackage

>>> rtl/core/lsd_radix_sort_24bit_keys_top.sv
// Top level of the stable LSD radix sorter for 24-bit keys.
// Usage: the input channel (i_cmd_valid, o_cmd_stall, i_cmd_data) carries one
// transaction per push or pop. A push stores a key and tag in arrival order;
// the push marked final_record starts the sort. A pop returns one transaction
// on the output channel (o_res_valid, i_res_stall, o_res_data): the next
// record in ascending key order, with out_last on the final one, or all
// zeros with out_valid low when no sorted record is waiting. Pushes give no
// output. A push to a full buffer is dropped, and a push while a sorted list
// is waiting discards that list and starts a new one.
// Sequence: a pop result is registered in the cycle after the buffer read.
// The sort runs NUM_PASSES passes, each a histogram clear over all
// 2^DIGIT_BITS bins, a count step per record, a prefix sum step per bin and
// a scatter step per record; count and scatter steps read the record, read
// its histogram bin and write it back; each prefix sum step reads and
// writes one bin. The input stalls during the sort, while a pop completes
// and while a result is held and stalled by the receiver. Reset clears
// the counters and the ready flag; the record buffers hold their contents
// and need no clearing pass.
module lsd_radix_sort_24bit_keys_top #(
    parameter int MAX_ITEMS  = lrs_pkg::DEF_MAX_ITEMS,
    parameter int DIGIT_BITS = lrs_pkg::DEF_DIGIT_BITS,
    parameter int NUM_PASSES = lrs_pkg::DEF_NUM_PASSES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    output logic               o_cmd_stall,
    input  lrs_pkg::t_cmd_item i_cmd_data,
    output logic               o_res_valid,
    input  logic               i_res_stall,
    output lrs_pkg::t_res_item o_res_data
);
    lrs_pkg::t_dp_cmd    dp_cmd;
    lrs_pkg::t_dp_status dp_status;

    // The sequencer decides each cycle's operation; the datapath owns all storage.
    lrs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (i_cmd_valid),
        .i_opcode    (i_cmd_data.opcode),
        .i_final     (i_cmd_data.final_record),
        .i_status    (dp_status),
        .o_cmd_stall (o_cmd_stall),
        .o_cmd       (dp_cmd)
    );

    lrs_dp #(
        .MAX_ITEMS  (MAX_ITEMS),
        .DIGIT_BITS (DIGIT_BITS),
        .NUM_PASSES (NUM_PASSES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .i_item      (i_cmd_data),
        .i_res_stall (i_res_stall),
        .o_status    (dp_status),
        .o_res_valid (o_res_valid),
        .o_res_data  (o_res_data)
    );
endmodule

>>> rtl/core/lrs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/core/lrs_ctrl.sv
// Sequencer of the radix sorter: issues one datapath command per cycle.
`include "lsd_radix_sort_24bit_keys_top_defines.svh"
module lrs_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    input  logic                i_opcode,
    input  logic                i_final,
    input  lrs_pkg::t_dp_status i_status,
    output logic                o_cmd_stall,
    output lrs_pkg::t_dp_cmd    o_cmd
);
    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_POP_WAIT = 4'd1;
    localparam logic [3:0] ST_CLR      = 4'd2;
    localparam logic [3:0] ST_CNT_RD   = 4'd3;
    localparam logic [3:0] ST_CNT_HR   = 4'd4;
    localparam logic [3:0] ST_CNT_WR   = 4'd5;
    localparam logic [3:0] ST_PRE_RD   = 4'd6;
    localparam logic [3:0] ST_PRE_WR   = 4'd7;
    localparam logic [3:0] ST_SC_RD    = 4'd8;
    localparam logic [3:0] ST_SC_HR    = 4'd9;
    localparam logic [3:0] ST_SC_WR    = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       accept;

    assign o_cmd_stall = !((r_state == ST_IDLE) && i_status.res_free);
    assign accept = i_cmd_valid && !o_cmd_stall;

    always_comb begin
        n_state  = r_state;
        o_cmd.op = lrs_pkg::CMD_NONE;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_opcode == lrs_pkg::OPC_PUSH) begin
                        o_cmd.op = lrs_pkg::CMD_PUSH;
                        if (i_final) n_state = ST_CLR;
                    end else if (i_status.pop_avail) begin
                        o_cmd.op = lrs_pkg::CMD_POP_START;
                        n_state  = ST_POP_WAIT;
                    end else begin
                        o_cmd.op = lrs_pkg::CMD_POP_EMPTY;
                    end
                end
            end
            ST_POP_WAIT: begin
                o_cmd.op = lrs_pkg::CMD_POP_DONE;
                n_state  = ST_IDLE;
            end
            ST_CLR: begin
                o_cmd.op = lrs_pkg::CMD_CLR;
                if (i_status.bin_last) n_state = ST_CNT_RD;
            end
            ST_CNT_RD: begin
                o_cmd.op = lrs_pkg::CMD_CNT_RD;
                n_state  = ST_CNT_HR;
            end
            ST_CNT_HR: begin
                o_cmd.op = lrs_pkg::CMD_CNT_HR;
                n_state  = ST_CNT_WR;
            end
            ST_CNT_WR: begin
                o_cmd.op = lrs_pkg::CMD_CNT_WR;
                n_state  = i_status.idx_last ? ST_PRE_RD : ST_CNT_RD;
            end
            ST_PRE_RD: begin
                o_cmd.op = lrs_pkg::CMD_PRE_RD;
                n_state  = ST_PRE_WR;
            end
            ST_PRE_WR: begin
                o_cmd.op = lrs_pkg::CMD_PRE_WR;
                n_state  = i_status.bin_last ? ST_SC_RD : ST_PRE_RD;
            end
            ST_SC_RD: begin
                o_cmd.op = lrs_pkg::CMD_SC_RD;
                n_state  = ST_SC_HR;
            end
            ST_SC_HR: begin
                o_cmd.op = lrs_pkg::CMD_SC_HR;
                n_state  = ST_SC_WR;
            end
            ST_SC_WR: begin
                o_cmd.op = lrs_pkg::CMD_SC_WR;
                if (!i_status.idx_last) begin
                    n_state = ST_SC_RD;
                end else begin
                    n_state = i_status.pass_last ? ST_IDLE : ST_CLR;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `LRS_ASSERT_NXT(a_pop_one_wait, r_state == ST_POP_WAIT, r_state == ST_IDLE,
        "pop read did not return to idle")
    `LRS_ASSERT_IMP(a_busy_stalls, r_state != ST_IDLE, o_cmd_stall,
        "input accepted while sorting")
    `LRS_ASSERT_NXT(a_final_push_sorts, accept && i_opcode == lrs_pkg::OPC_PUSH && i_final,
        r_state == ST_CLR, "final push did not start the sort")
endmodule

>>> rtl/core/lrs_dp.sv
// Datapath of the radix sorter: record buffers, histogram, counters, output register.
`include "lsd_radix_sort_24bit_keys_top_defines.svh"
module lrs_dp #(
    parameter int MAX_ITEMS  = lrs_pkg::DEF_MAX_ITEMS,
    parameter int DIGIT_BITS = lrs_pkg::DEF_DIGIT_BITS,
    parameter int NUM_PASSES = lrs_pkg::DEF_NUM_PASSES
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lrs_pkg::t_dp_cmd    i_cmd,
    input  lrs_pkg::t_cmd_item  i_item,
    input  logic                i_res_stall,
    output lrs_pkg::t_dp_status o_status,
    output logic                o_res_valid,
    output lrs_pkg::t_res_item  o_res_data
);
    localparam int AW  = $clog2(MAX_ITEMS);
    localparam int CW  = $clog2(MAX_ITEMS + 1);
    localparam int DB  = DIGIT_BITS;
    localparam int NB  = 1 << DIGIT_BITS;
    localparam int PW  = (NUM_PASSES > 1) ? $clog2(NUM_PASSES) : 1;
    localparam int SHW = 8;
    localparam logic RES_IN_B = (NUM_PASSES % 2) == 1;

    logic [CW-1:0]             r_count;
    logic [CW-1:0]             r_read_pos;
    logic                      r_ready;
    logic [AW-1:0]             r_idx;
    logic [DB-1:0]             r_bin;
    logic [PW-1:0]             r_pass;
    logic [CW-1:0]             r_sum;
    logic [DB-1:0]             r_digit;
    logic [lrs_pkg::REC_W-1:0] r_rec;
    logic                      r_res_valid;
    logic                      n_res_valid;
    lrs_pkg::t_res_item        r_res;

    logic [lrs_pkg::REC_W-1:0] a_rdata, b_rdata, src_rdata, res_rdata;
    logic                      a_we, b_we;
    logic [AW-1:0]             a_waddr, b_waddr, rec_raddr;
    logic [lrs_pkg::REC_W-1:0] a_wdata, b_wdata;
    logic                      h_we;
    logic [DB-1:0]             h_waddr, h_raddr;
    logic [CW-1:0]             h_wdata, h_rdata;
    logic [CW-1:0]             count_eff;
    logic [SHW-1:0]            shift;
    logic [DB-1:0]             src_digit;
    logic                      src_is_b;

    assign src_is_b  = r_pass[0];
    assign src_rdata = src_is_b ? b_rdata : a_rdata;
    assign res_rdata = RES_IN_B ? b_rdata : a_rdata;
    assign count_eff = r_ready ? '0 : r_count;

    // Digit of the record being read; a digit wholly above the key is zero.
    assign shift = SHW'(r_pass) * SHW'(DIGIT_BITS);
    always_comb begin
        if (shift >= SHW'(lrs_pkg::KEY_W)) begin
            src_digit = '0;
        end else begin
            src_digit = DB'(src_rdata[lrs_pkg::REC_W-1 -: lrs_pkg::KEY_W] >> shift);
        end
    end

    assign rec_raddr = (i_cmd.op == lrs_pkg::CMD_POP_START) ? r_read_pos[AW-1:0] : r_idx;

    always_comb begin
        a_we    = 1'b0;
        b_we    = 1'b0;
        a_waddr = h_rdata[AW-1:0];
        b_waddr = h_rdata[AW-1:0];
        a_wdata = r_rec;
        b_wdata = r_rec;
        if (i_cmd.op == lrs_pkg::CMD_PUSH) begin
            a_we    = count_eff < CW'(MAX_ITEMS);
            a_waddr = count_eff[AW-1:0];
            a_wdata = {i_item.sort_key, i_item.record_tag};
        end else if (i_cmd.op == lrs_pkg::CMD_SC_WR) begin
            a_we = src_is_b;
            b_we = !src_is_b;
        end
    end

    always_comb begin
        h_we    = 1'b0;
        h_waddr = r_bin;
        h_wdata = '0;
        h_raddr = r_bin;
        unique case (i_cmd.op)
            lrs_pkg::CMD_CLR: begin
                h_we = 1'b1;
            end
            lrs_pkg::CMD_CNT_HR, lrs_pkg::CMD_SC_HR: begin
                h_raddr = src_digit;
            end
            lrs_pkg::CMD_CNT_WR, lrs_pkg::CMD_SC_WR: begin
                h_we    = 1'b1;
                h_waddr = r_digit;
                h_wdata = h_rdata + CW'(1);
            end
            lrs_pkg::CMD_PRE_WR: begin
                h_we    = 1'b1;
                h_wdata = r_sum;
            end
            default: begin
            end
        endcase
    end

    // A held result stays while stalled; a pop loads a new one.
    always_comb begin
        n_res_valid = r_res_valid && i_res_stall;
        if (i_cmd.op == lrs_pkg::CMD_POP_EMPTY || i_cmd.op == lrs_pkg::CMD_POP_DONE) begin
            n_res_valid = 1'b1;
        end
    end

    lrs_ram #(.WIDTH(lrs_pkg::REC_W), .DEPTH(MAX_ITEMS)) u_buf_a (
        .i_clk(i_clk), .i_we(a_we), .i_waddr(a_waddr), .i_wdata(a_wdata),
        .i_raddr(rec_raddr), .o_rdata(a_rdata)
    );

    lrs_ram #(.WIDTH(lrs_pkg::REC_W), .DEPTH(MAX_ITEMS)) u_buf_b (
        .i_clk(i_clk), .i_we(b_we), .i_waddr(b_waddr), .i_wdata(b_wdata),
        .i_raddr(rec_raddr), .o_rdata(b_rdata)
    );

    lrs_ram #(.WIDTH(CW), .DEPTH(NB)) u_hist (
        .i_clk(i_clk), .i_we(h_we), .i_waddr(h_waddr), .i_wdata(h_wdata),
        .i_raddr(h_raddr), .o_rdata(h_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_read_pos  <= '0;
            r_ready     <= 1'b0;
            r_idx       <= '0;
            r_bin       <= '0;
            r_pass      <= '0;
            r_sum       <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= n_res_valid;
            unique case (i_cmd.op)
                lrs_pkg::CMD_PUSH: begin
                    r_ready    <= 1'b0;
                    r_read_pos <= '0;
                    r_count    <= (count_eff < CW'(MAX_ITEMS)) ? count_eff + CW'(1)
                                                               : count_eff;
                    r_idx      <= '0;
                    r_bin      <= '0;
                    r_pass     <= '0;
                    r_sum      <= '0;
                end
                lrs_pkg::CMD_POP_DONE: begin
                    if (r_read_pos + CW'(1) == r_count) begin
                        r_ready    <= 1'b0;
                        r_count    <= '0;
                        r_read_pos <= '0;
                    end else begin
                        r_read_pos <= r_read_pos + CW'(1);
                    end
                end
                lrs_pkg::CMD_CLR: begin
                    r_bin <= r_bin + DB'(1);
                    r_idx <= '0;
                    r_sum <= '0;
                end
                lrs_pkg::CMD_CNT_WR: begin
                    r_idx <= o_status.idx_last ? '0 : r_idx + AW'(1);
                end
                lrs_pkg::CMD_PRE_WR: begin
                    r_sum <= r_sum + h_rdata;
                    r_bin <= r_bin + DB'(1);
                end
                lrs_pkg::CMD_SC_WR: begin
                    r_idx <= o_status.idx_last ? '0 : r_idx + AW'(1);
                    if (o_status.idx_last) begin
                        if (o_status.pass_last) begin
                            r_ready    <= 1'b1;
                            r_read_pos <= '0;
                        end else begin
                            r_pass <= r_pass + PW'(1);
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == lrs_pkg::CMD_CNT_HR || i_cmd.op == lrs_pkg::CMD_SC_HR) begin
            r_digit <= src_digit;
            r_rec   <= src_rdata;
        end
        if (i_cmd.op == lrs_pkg::CMD_POP_EMPTY) begin
            r_res <= '0;
        end else if (i_cmd.op == lrs_pkg::CMD_POP_DONE) begin
            r_res.out_key   <= res_rdata[lrs_pkg::REC_W-1 -: lrs_pkg::KEY_W];
            r_res.out_tag   <= res_rdata[lrs_pkg::TAG_W-1:0];
            r_res.out_last  <= (r_read_pos + CW'(1) == r_count);
            r_res.out_valid <= 1'b1;
        end
    end

    assign o_status.idx_last  = (CW'(r_idx) + CW'(1) == r_count);
    assign o_status.bin_last  = (r_bin == DB'(NB - 1));
    assign o_status.pass_last = (r_pass == PW'(NUM_PASSES - 1));
    assign o_status.pop_avail = r_ready && (r_read_pos < r_count);
    assign o_status.res_free  = !r_res_valid || !i_res_stall;

    assign o_res_valid = r_res_valid;
    assign o_res_data  = r_res;

    `LRS_ASSERT_IMP(a_count_range, 1'b1, r_count <= CW'(MAX_ITEMS),
        "record count above capacity")
    `LRS_ASSERT_IMP(a_ready_nonempty, r_ready, r_read_pos < r_count,
        "sorted list ready with no record left")
    `LRS_ASSERT_NXT(a_push_clears_ready, i_cmd.op == lrs_pkg::CMD_PUSH, !r_ready,
        "push left an old list ready")
endmodule
